>>> rtl/core/homogeneous_point_projection_assert.svh
// Assertion macros used by the RTL of the point projection block.
`ifndef HOMOGENEOUS_POINT_PROJECTION_ASSERT_SVH
`define HOMOGENEOUS_POINT_PROJECTION_ASSERT_SVH

`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define HPP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Check a property on every clock edge, reset included.
`define HPP_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HPP_ASSERT(lbl, prop, msg)
`define HPP_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

>>> rtl/core/hpp_pkg.sv
`timescale 1ns / 1ps
package hpp_pkg;

	localparam int FRAC_BITS = 16;
	localparam int CO_W      = 32;
	localparam int PROD_W    = 2 * CO_W;
	localparam int SUM_W     = PROD_W + 2;
	localparam int MAG_W     = SUM_W - 1;
	localparam int Q_W       = CO_W + 1;
	localparam int CMP_W     = MAG_W + Q_W;
	localparam int PROJ_N    = 12;
	localparam int MODEL_N   = 16;
	localparam int IDX_W     = 4;

	localparam logic [CO_W-1:0] ONE     = {{(CO_W-1){1'b0}}, 1'b1} << FRAC_BITS;
	localparam logic [CO_W-1:0] SAT_POS = {1'b0, {(CO_W-1){1'b1}}};
	localparam logic [CO_W-1:0] SAT_NEG = {1'b1, {(CO_W-1){1'b0}}};

	typedef enum logic [1:0] {
		OP_LOAD_PROJ  = 2'd0,
		OP_LOAD_MODEL = 2'd1,
		OP_PROJECT    = 2'd2,
		OP_TRANSFORM  = 2'd3
	} op_t;

	localparam logic [1:0] FAULT_OK       = 2'd0;
	localparam logic [1:0] FAULT_DIV_ZERO = 2'd1;
	localparam logic [1:0] FAULT_SAT      = 2'd2;

	localparam logic KIND_IMAGE = 1'b0;
	localparam logic KIND_MODEL = 1'b1;

	typedef struct packed {
		op_t                    operation;
		logic [IDX_W-1:0]       coeff_index;
		logic signed [CO_W-1:0] coeff_value;
		logic signed [CO_W-1:0] point_x;
		logic signed [CO_W-1:0] point_y;
		logic signed [CO_W-1:0] point_z;
	} item_t;

	typedef struct packed {
		logic                   result_kind;
		logic signed [CO_W-1:0] out_x;
		logic signed [CO_W-1:0] out_y;
		logic signed [CO_W-1:0] out_z;
		logic [1:0]             fault;
	} result_t;

	typedef struct packed {
		logic       kind;
		logic       dz;
		logic [2:0] neg;
		logic [2:0] ovf;
	} meta_t;

	typedef struct packed {
		logic [MAG_W-1:0]         den;
		logic [2:0][MAG_W-1:0]    rem;
		logic [2:0][Q_W-1:0]      nq;
		meta_t                    meta;
	} div_t;

endpackage

>>> rtl/core/hpp_div_step.sv
`timescale 1ns / 1ps
module hpp_div_step import hpp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_vld,
	input  div_t din,
	output logic out_vld,
	output div_t dout
);

	div_t             nxt;
	logic [MAG_W:0]   rem2;
	logic             take;
	logic             vld_q;
	div_t             div_q;

	// One restoring step per lane: bring down the next dividend bit, trial subtract.
	always_comb begin
		nxt  = din;
		rem2 = '0;
		take = 1'b0;
		for (int l = 0; l < 3; l++) begin
			rem2 = {din.rem[l], din.nq[l][Q_W-1]};
			take = rem2 >= {1'b0, din.den};
			nxt.rem[l] = take ? MAG_W'(rem2 - {1'b0, din.den}) : rem2[MAG_W-1:0];
			nxt.nq[l]  = {din.nq[l][Q_W-2:0], take};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			div_q <= nxt;
		end
	end

	assign out_vld = vld_q;
	assign dout    = div_q;

endmodule

>>> rtl/core/homogeneous_point_projection.sv
`timescale 1ns / 1ps
// Homogeneous point projection. Load transactions write one coefficient of the 3x4
// projection matrix or the 4x4 model matrix (row-major, Q16.16); a project transaction
// returns the image point (rows 0 and 1 divided by row 2), a transform transaction the
// model point (rows 0 to 2 divided by row 3). Loads give no result and take effect for
// every later transaction. One transaction enters per cycle while item_stall is low;
// a result passes through the five multiply/sum/prepare stages, the 33 stages of the
// pipelined divider (one quotient bit each) and the output register. A held result
// does not stop the pipeline until one more result has filled the skid register.
// Fault 1 flags a zero divisor (all coordinates zero), fault 2 a saturated quotient.
module homogeneous_point_projection import hpp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	logic [CO_W-1:0] pc_q [PROJ_N];
	logic [CO_W-1:0] mc_q [MODEL_N];

	logic accept;
	logic is_pt;
	logic en;

	logic signed [CO_W-1:0] coef_sel [4][4];

	logic                   vld_s1;
	logic                   kind_s1;
	logic signed [CO_W-1:0] coef_s1 [4][4];
	logic signed [CO_W-1:0] pt_s1 [3];

	logic                     vld_s2;
	logic                     kind_s2;
	logic signed [PROD_W-1:0] prod_s2 [4][3];
	logic signed [CO_W-1:0]   off_s2 [4];

	logic                    vld_s3;
	logic                    kind_s3;
	logic signed [SUM_W-1:0] sum_s3 [4];

	logic             vld_s4;
	logic             kind_s4;
	logic             dz_s4;
	logic [2:0]       neg_s4;
	logic [MAG_W-1:0] mag_s4 [4];

	logic vld_s5;
	div_t div_s5;
	div_t div_nxt;
	logic [CMP_W-1:0] nx;

	div_t dv [Q_W+1];
	logic vv [Q_W+1];

	result_t fin;
	logic [Q_W-1:0]  q;
	logic            sat;
	logic            any_sat;
	logic [CO_W-1:0] lane [3];

	result_t out_q;
	logic    out_v_q;
	result_t skid_q;
	logic    skid_v_q;
	logic    out_take;

	assign item_stall = skid_v_q;
	assign accept     = item_valid && !item_stall;
	assign is_pt      = item.operation == OP_PROJECT || item.operation == OP_TRANSFORM;
	assign en         = !skid_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PROJ_N; i++) begin
				pc_q[i] <= (i == 0 || i == 5 || i == 10) ? ONE : '0;
			end
			for (int i = 0; i < MODEL_N; i++) begin
				mc_q[i] <= (i == 0 || i == 5 || i == 10 || i == 15) ? ONE : '0;
			end
		end else if (accept) begin
			if (item.operation == OP_LOAD_PROJ && item.coeff_index < IDX_W'(PROJ_N)) begin
				pc_q[item.coeff_index] <= item.coeff_value;
			end
			if (item.operation == OP_LOAD_MODEL) begin
				mc_q[item.coeff_index] <= item.coeff_value;
			end
		end
	end

	// Projection puts its divisor row in slot 3 and a zero row in slot 2.
	always_comb begin
		for (int r = 0; r < 4; r++) begin
			for (int k = 0; k < 4; k++) begin
				if (item.operation == OP_PROJECT) begin
					if (r == 3) begin
						coef_sel[r][k] = pc_q[8 + k];
					end else if (r == 2) begin
						coef_sel[r][k] = '0;
					end else begin
						coef_sel[r][k] = pc_q[4 * r + k];
					end
				end else begin
					coef_sel[r][k] = mc_q[4 * r + k];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= accept && is_pt;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_comb begin
		div_nxt      = '0;
		nx           = '0;
		div_nxt.den  = mag_s4[3];
		div_nxt.meta = '{kind: kind_s4, dz: dz_s4, neg: neg_s4, ovf: 3'b000};
		for (int l = 0; l < 3; l++) begin
			nx = CMP_W'(mag_s4[l]) << FRAC_BITS;
			div_nxt.meta.ovf[l] = nx >= {mag_s4[3], {Q_W{1'b0}}};
			div_nxt.rem[l]      = nx[CMP_W-1:Q_W];
			div_nxt.nq[l]       = nx[Q_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s1 <= item.operation == OP_TRANSFORM ? KIND_MODEL : KIND_IMAGE;
			coef_s1 <= coef_sel;
			pt_s1[0] <= item.point_x;
			pt_s1[1] <= item.point_y;
			pt_s1[2] <= item.point_z;

			kind_s2 <= kind_s1;
			for (int r = 0; r < 4; r++) begin
				for (int k = 0; k < 3; k++) begin
					prod_s2[r][k] <= coef_s1[r][k] * pt_s1[k];
				end
				off_s2[r] <= coef_s1[r][3];
			end

			kind_s3 <= kind_s2;
			for (int r = 0; r < 4; r++) begin
				sum_s3[r] <= SUM_W'(prod_s2[r][0]) + SUM_W'(prod_s2[r][1])
					+ SUM_W'(prod_s2[r][2]) + (SUM_W'(off_s2[r]) <<< FRAC_BITS);
			end

			kind_s4 <= kind_s3;
			dz_s4   <= sum_s3[3] == '0;
			for (int r = 0; r < 4; r++) begin
				mag_s4[r] <= sum_s3[r][SUM_W-1] ? MAG_W'(-sum_s3[r]) : MAG_W'(sum_s3[r]);
			end
			for (int l = 0; l < 3; l++) begin
				neg_s4[l] <= sum_s3[l][SUM_W-1] ^ sum_s3[3][SUM_W-1];
			end

			div_s5 <= div_nxt;
		end
	end

	assign dv[0] = div_s5;
	assign vv[0] = vld_s5;

	for (genvar g = 0; g < Q_W; g++) begin : g_div
		hpp_div_step u_step (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.in_vld  (vv[g]),
			.din     (dv[g]),
			.out_vld (vv[g+1]),
			.dout    (dv[g+1])
		);
	end

	// Saturate, apply sign and pick the fault code.
	always_comb begin
		q       = '0;
		sat     = 1'b0;
		any_sat = 1'b0;
		for (int l = 0; l < 3; l++) begin
			q   = dv[Q_W].nq[l];
			sat = dv[Q_W].meta.ovf[l]
				|| q > (dv[Q_W].meta.neg[l] ? Q_W'(SAT_NEG) : Q_W'(SAT_POS));
			any_sat = any_sat || sat;
			if (sat) begin
				lane[l] = dv[Q_W].meta.neg[l] ? SAT_NEG : SAT_POS;
			end else if (dv[Q_W].meta.neg[l]) begin
				lane[l] = -q[CO_W-1:0];
			end else begin
				lane[l] = q[CO_W-1:0];
			end
		end
		fin.result_kind = dv[Q_W].meta.kind;
		if (dv[Q_W].meta.dz) begin
			fin.out_x = '0;
			fin.out_y = '0;
			fin.out_z = '0;
			fin.fault = FAULT_DIV_ZERO;
		end else begin
			fin.out_x = lane[0];
			fin.out_y = lane[1];
			fin.out_z = lane[2];
			fin.fault = any_sat ? FAULT_SAT : FAULT_OK;
		end
	end

	assign out_take = !out_v_q || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (out_take) begin
			out_v_q  <= skid_v_q || vv[Q_W];
			skid_v_q <= 1'b0;
		end else if (en && vv[Q_W]) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_take) begin
			out_q <= skid_v_q ? skid_q : fin;
		end else if (en) begin
			skid_q <= fin;
		end
	end

	assign result_valid = out_v_q;
	assign result       = out_q;

	`include "homogeneous_point_projection_assert.svh"

	`HPP_ASSERT(a_skid_behind_out, skid_v_q |-> out_v_q, "skid full without a held result")
	`HPP_ASSERT(a_dz_zero, out_v_q && out_q.fault == FAULT_DIV_ZERO |-> out_q.out_x == '0 && out_q.out_y == '0 && out_q.out_z == '0, "zero divisor result not cleared")
	`HPP_ASSERT(a_image_z, out_v_q && out_q.result_kind == KIND_IMAGE |-> out_q.out_z == '0, "image point with nonzero z")
	`HPP_ASSERT(a_skid_fill, !out_v_q |=> !skid_v_q, "skid filled while output was free")

endmodule
